@@ src/rgl_pkg.sv @@
// Shared types, constants and helper functions for the region growing labeler.
`timescale 1ns / 1ps
package rgl_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int IDX_W      = ROW_W + COL_W;
    localparam int STORE_SIZE = MAX_ROWS * MAX_COLS;
    localparam int CNT_W      = 13;
    localparam int LABEL_W    = 13;
    localparam int PIX_W      = 24;
    localparam int THR_W      = 9;
    localparam int SIZE_W     = 7;
    localparam int SQ_W       = 18;
    localparam int NB_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Input command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_GROW = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_GROW,
        OP_READ
    } rgl_op_t;

    typedef struct packed {
        rgl_op_t              op;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [PIX_W-1:0]     pixel;
    } rgl_cmd_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic              color_mode;
        logic [SIZE_W-1:0] image_rows;
        logic [SIZE_W-1:0] image_cols;
    } rgl_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_W,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_POP_W,
        ST_CUR_W,
        ST_NB,
        ST_NB_W,
        ST_NB_SQ,
        ST_NB_CMP,
        ST_SCAN,
        ST_SCAN_W,
        ST_DONE
    } rgl_state_t;

    // Row step of neighbour k, visit order as in the growth definition
    function automatic logic signed [1:0] nbr_drow(input logic [NB_W-1:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0:    d = -2'sd1;
            3'd1:    d =  2'sd0;
            3'd2:    d =  2'sd1;
            3'd3:    d =  2'sd1;
            3'd4:    d =  2'sd1;
            3'd5:    d =  2'sd0;
            3'd6:    d = -2'sd1;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

    // Column step of neighbour k
    function automatic logic signed [1:0] nbr_dcol(input logic [NB_W-1:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0:    d = -2'sd1;
            3'd1:    d = -2'sd1;
            3'd2:    d = -2'sd1;
            3'd3:    d =  2'sd0;
            3'd4:    d =  2'sd1;
            3'd5:    d =  2'sd1;
            3'd6:    d =  2'sd1;
            default: d =  2'sd0;
        endcase
        return d;
    endfunction

    // Clamp a configured image size to 1..limit
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ src/rgl_if.sv @@
// Request and result channel interfaces of the region growing labeler.
`timescale 1ns / 1ps
interface rgl_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;

    modport source (output valid, command, row, col, chan0, chan1, chan2, input ready);
    modport sink   (input valid, command, row, col, chan0, chan1, chan2, output ready);
endinterface

interface rgl_rsp_if;
    logic        valid;
    logic        ready;
    logic [12:0] label;
    logic [12:0] region_count;

    modport source (output valid, label, region_count, input ready);
    modport sink   (input valid, label, region_count, output ready);
endinterface

@@ src/region_growing_labeler_top.sv @@
// Top level of the region growing labeler: configuration registers, front and back ends.
//
//  channel | direction | payload                                | handshake
//  req     | in        | command, row, col, chan0, chan1, chan2 | valid / ready
//  rsp     | out       | label, region_count                    | valid / ready
//  cfg     | in        | cfg_index, cfg_data                    | cfg_write
//
// Loads stream at one per cycle while the back end is idle. A read passes through ST_READ_W
// before posting its result. A grow first clears the 4096-entry label store, then labels
// each seed, pops the pending queue, reads and tests each in-image neighbour, skips each
// neighbour outside the image, scans pixels for the next seed and then posts the result.
// Labels read as 0 from reset until the first grow.
// A two-entry request queue accepts until full, while the back end works or a result waits.
`timescale 1ns / 1ps
module region_growing_labeler_top
    import rgl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rgl_req_if.sink               req,
    rgl_rsp_if.source             rsp,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rgl_cfg_t cfg_reg, cfg_next;
    logic     cmd_valid;
    rgl_cmd_t cmd;
    logic     cmd_pop;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:  cfg_next.threshold  = cfg_data[THR_W-1:0];
                CFG_COLOR_MODE: cfg_next.color_mode = cfg_data[0];
                CFG_IMAGE_ROWS: cfg_next.image_rows = cfg_data[SIZE_W-1:0];
                CFG_IMAGE_COLS: cfg_next.image_cols = cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= THR_W'(10);
            cfg_reg.color_mode <= 1'b0;
            cfg_reg.image_rows <= SIZE_W'(MAX_ROWS);
            cfg_reg.image_cols <= SIZE_W'(MAX_COLS);
        end
        else
            cfg_reg <= cfg_next;
    end

    rgl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    rgl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

@@ src/rgl_front.sv @@
// Front end: takes requests, decodes the command and queues it for the back end.
`timescale 1ns / 1ps
module rgl_front
    import rgl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rgl_req_if.sink   req,
    output logic      cmd_valid,
    output rgl_cmd_t  cmd,
    input  logic      cmd_pop
);

    rgl_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       take;
    logic       push;
    logic       pop;
    rgl_cmd_t   dec;

    assign req.ready = (count_reg != 2'd2);
    assign take      = req.valid && req.ready;

    // Decode the command; unknown codes are dropped here
    always_comb
    begin
        dec.row   = req.row;
        dec.col   = req.col;
        dec.pixel = {req.chan2, req.chan1, req.chan0};
        dec.op    = OP_LOAD;
        push      = take;
        unique case (req.command)
            CMD_LOAD: dec.op = OP_LOAD;
            CMD_GROW: dec.op = OP_GROW;
            CMD_READ: dec.op = OP_READ;
            default:
            begin
                dec.op = OP_LOAD;
                push   = 1'b0;
            end
        endcase
    end

    assign pop       = cmd_pop && (count_reg != 2'd0);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= dec;
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("front queue count out of range");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) && !pop |=> count_reg == 2'd2)
        else $error("front queue changed while full and not popped");

    a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rd_ptr_reg != $past(rd_ptr_reg))
        else $error("front queue read pointer did not advance");

endmodule

@@ src/rgl_back.sv @@
// Back end: pixel, label and pending memories and the region growing sequencer.
`timescale 1ns / 1ps
module rgl_back
    import rgl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rgl_cfg_t  cfg,
    input  logic      cmd_valid,
    input  rgl_cmd_t  cmd,
    output logic      cmd_pop,
    rgl_rsp_if.source rsp
);

    localparam logic [SIZE_W-1:0] ROWS_LIM = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] COLS_LIM = SIZE_W'(MAX_COLS);
    localparam logic [CNT_W-1:0]  LAST_IDX = CNT_W'(STORE_SIZE - 1);
    localparam logic [CNT_W-1:0]  Q_LIMIT  = CNT_W'(STORE_SIZE);

    // Memories
    logic [PIX_W-1:0]   pix_mem [STORE_SIZE];
    logic [LABEL_W-1:0] lab_mem [STORE_SIZE];
    logic [IDX_W-1:0]   q_mem   [STORE_SIZE];

    logic               pix_we;
    logic [IDX_W-1:0]   pix_waddr;
    logic [PIX_W-1:0]   pix_wdata;
    logic [IDX_W-1:0]   pix_raddr;
    logic [PIX_W-1:0]   pix_rdata_reg;
    logic               lab_we;
    logic [IDX_W-1:0]   lab_waddr;
    logic [LABEL_W-1:0] lab_wdata;
    logic [IDX_W-1:0]   lab_raddr;
    logic [LABEL_W-1:0] lab_rdata_reg;
    logic               q_we;
    logic [IDX_W-1:0]   q_waddr;
    logic [IDX_W-1:0]   q_wdata;
    logic [IDX_W-1:0]   q_raddr;
    logic [IDX_W-1:0]   q_rdata_reg;

    rgl_state_t state_reg, state_next;

    logic [CNT_W-1:0]   clr_reg, clr_next;
    logic [ROW_W-1:0]   seed_row_reg, seed_row_next;
    logic [COL_W-1:0]   seed_col_reg, seed_col_next;
    logic [SIZE_W-1:0]  rows_reg, rows_next;
    logic [SIZE_W-1:0]  cols_reg, cols_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [SQ_W-1:0]    thr_sq_reg, thr_sq_next;
    logic [CNT_W-1:0]   region_reg, region_next;
    logic [CNT_W-1:0]   labelled_reg, labelled_next;
    logic [ROW_W-1:0]   scan_row_reg, scan_row_next;
    logic [COL_W-1:0]   scan_col_reg, scan_col_next;
    logic [CNT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   tail_reg, tail_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [PIX_W-1:0]   cur_px_reg, cur_px_next;
    logic [NB_W-1:0]    nb_reg, nb_next;
    logic [IDX_W-1:0]   ni_reg, ni_next;
    logic [7:0]         d0_reg, d0_next;
    logic [7:0]         d1_reg, d1_next;
    logic [7:0]         d2_reg, d2_next;
    logic [15:0]        sq0_reg, sq0_next;
    logic [15:0]        sq1_reg, sq1_next;
    logic [15:0]        sq2_reg, sq2_next;
    logic               free_reg, free_next;
    logic               lvalid_reg, lvalid_next;
    logic               out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0] out_label_reg, out_label_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    logic               out_free;
    logic               accept;
    logic signed [7:0]  nr;
    logic signed [7:0]  nc;
    logic               nb_out;
    logic [SQ_W-1:0]    sq_sum;
    logic               joins;
    logic               last_nb;
    logic [SIZE_W-1:0]  scan_col_inc;

    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = (state_reg == ST_IDLE) && cmd_valid &&
                      ((cmd.op == OP_LOAD) || out_free);
    assign cmd_pop  = accept;

    // Neighbour position and bounds
    assign nr     = $signed({2'b00, cur_reg[IDX_W-1:COL_W]}) + 8'(nbr_drow(nb_reg));
    assign nc     = $signed({2'b00, cur_reg[COL_W-1:0]}) + 8'(nbr_dcol(nb_reg));
    assign nb_out = nr[7] || nc[7] || (nr >= $signed({1'b0, rows_reg})) ||
                    (nc >= $signed({1'b0, cols_reg}));
    assign last_nb = (nb_reg == NB_W'(7));

    // Join test
    assign sq_sum = SQ_W'(sq0_reg) + SQ_W'(sq1_reg) + SQ_W'(sq2_reg);
    assign joins  = free_reg && (cfg.color_mode ? (sq_sum < thr_sq_reg)
                                                : ({1'b0, d0_reg} < cfg.threshold));
    assign scan_col_inc = {1'b0, scan_col_reg} + SIZE_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (cmd.op == OP_GROW)
                        state_next = ST_CLEAR;
                    else if (cmd.op == OP_READ)
                        state_next = ST_READ_W;
                end
            ST_READ_W: state_next = ST_IDLE;
            ST_CLEAR:  if (clr_reg == LAST_IDX) state_next = ST_SEED;
            ST_SEED:   state_next = ST_POP;
            ST_POP:
                if (head_reg == tail_reg)
                    state_next = (labelled_reg == total_reg) ? ST_DONE : ST_SCAN;
                else
                    state_next = ST_POP_W;
            ST_POP_W:  state_next = ST_CUR_W;
            ST_CUR_W:  state_next = ST_NB;
            ST_NB:
                if (!nb_out)
                    state_next = ST_NB_W;
                else if (last_nb)
                    state_next = ST_POP;
            ST_NB_W:   state_next = ST_NB_SQ;
            ST_NB_SQ:  state_next = ST_NB_CMP;
            ST_NB_CMP: state_next = last_nb ? ST_POP : ST_NB;
            ST_SCAN:   state_next = ST_SCAN_W;
            ST_SCAN_W: state_next = (lab_rdata_reg == '0) ? ST_SEED : ST_SCAN;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        clr_next       = clr_reg;
        seed_row_next  = seed_row_reg;
        seed_col_next  = seed_col_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        total_next     = total_reg;
        thr_sq_next    = thr_sq_reg;
        region_next    = region_reg;
        labelled_next  = labelled_reg;
        scan_row_next  = scan_row_reg;
        scan_col_next  = scan_col_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        cur_px_next    = cur_px_reg;
        nb_next        = nb_reg;
        ni_next        = ni_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        sq0_next       = sq0_reg;
        sq1_next       = sq1_reg;
        sq2_next       = sq2_reg;
        free_next      = free_reg;
        lvalid_next    = lvalid_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_label_next = out_label_reg;
        out_count_next = out_count_reg;

        pix_we    = 1'b0;
        pix_waddr = {cmd.row, cmd.col};
        pix_wdata = cmd.pixel;
        pix_raddr = ni_reg;
        lab_we    = 1'b0;
        lab_waddr = ni_reg;
        lab_wdata = region_reg;
        lab_raddr = {cmd.row, cmd.col};
        q_we      = 1'b0;
        q_waddr   = tail_reg[IDX_W-1:0];
        q_wdata   = ni_reg;
        q_raddr   = head_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (cmd.op == OP_LOAD)
                        pix_we = 1'b1;
                    if (cmd.op == OP_GROW)
                    begin
                        seed_row_next = cmd.row;
                        seed_col_next = cmd.col;
                        rows_next     = eff_size(cfg.image_rows, ROWS_LIM);
                        cols_next     = eff_size(cfg.image_cols, COLS_LIM);
                        clr_next      = '0;
                        region_next   = '0;
                        labelled_next = '0;
                        scan_row_next = '0;
                    end
                end
            ST_READ_W:
            begin
                out_valid_next = 1'b1;
                out_label_next = lvalid_reg ? lab_rdata_reg : '0;
                out_count_next = region_reg;
            end
            ST_CLEAR:
            begin
                // sweep the label store to zero
                lab_we      = 1'b1;
                lab_waddr   = clr_reg[IDX_W-1:0];
                lab_wdata   = '0;
                clr_next    = clr_reg + CNT_W'(1);
                total_next  = CNT_W'(rows_reg * cols_reg);
                thr_sq_next = SQ_W'(cfg.threshold * cfg.threshold);
                lvalid_next = 1'b1;
                if (clr_reg == '0 &&
                    (({1'b0, seed_row_reg} >= rows_reg) || ({1'b0, seed_col_reg} >= cols_reg)))
                begin
                    seed_row_next = '0;
                    seed_col_next = '0;
                end
            end
            ST_SEED:
            begin
                region_next   = region_reg + CNT_W'(1);
                labelled_next = labelled_reg + CNT_W'(1);
                lab_we        = 1'b1;
                lab_waddr     = {seed_row_reg, seed_col_reg};
                lab_wdata     = region_reg + CNT_W'(1);
                q_we          = 1'b1;
                q_waddr       = '0;
                q_wdata       = {seed_row_reg, seed_col_reg};
                head_next     = '0;
                tail_next     = CNT_W'(1);
            end
            ST_POP:
            begin
                q_raddr = head_reg[IDX_W-1:0];
                if (head_reg != tail_reg)
                    head_next = head_reg + CNT_W'(1);
                scan_col_next = '0;
            end
            ST_POP_W:
            begin
                cur_next  = q_rdata_reg;
                pix_raddr = q_rdata_reg;
            end
            ST_CUR_W:
            begin
                cur_px_next = pix_rdata_reg;
                nb_next     = '0;
            end
            ST_NB:
            begin
                ni_next   = {nr[ROW_W-1:0], nc[COL_W-1:0]};
                pix_raddr = {nr[ROW_W-1:0], nc[COL_W-1:0]};
                lab_raddr = {nr[ROW_W-1:0], nc[COL_W-1:0]};
                if (nb_out)
                    nb_next = nb_reg + NB_W'(1);
            end
            ST_NB_W:
            begin
                free_next = (lab_rdata_reg == '0);
                d0_next   = abs_diff(cur_px_reg[7:0],   pix_rdata_reg[7:0]);
                d1_next   = abs_diff(cur_px_reg[15:8],  pix_rdata_reg[15:8]);
                d2_next   = abs_diff(cur_px_reg[23:16], pix_rdata_reg[23:16]);
            end
            ST_NB_SQ:
            begin
                sq0_next = d0_reg * d0_reg;
                sq1_next = d1_reg * d1_reg;
                sq2_next = d2_reg * d2_reg;
            end
            ST_NB_CMP:
            begin
                nb_next = nb_reg + NB_W'(1);
                if (joins)
                begin
                    lab_we        = 1'b1;
                    labelled_next = labelled_reg + CNT_W'(1);
                    if (tail_reg < Q_LIMIT)
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + CNT_W'(1);
                    end
                end
            end
            ST_SCAN:
                lab_raddr = {scan_row_reg, scan_col_reg};
            ST_SCAN_W:
                if (lab_rdata_reg == '0)
                begin
                    seed_row_next = scan_row_reg;
                    seed_col_next = scan_col_reg;
                end
                else if (scan_col_inc >= cols_reg)
                begin
                    scan_col_next = '0;
                    scan_row_next = scan_row_reg + ROW_W'(1);
                end
                else
                    scan_col_next = scan_col_inc[COL_W-1:0];
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                out_label_next = '0;
                out_count_next = region_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            region_reg    <= '0;
            labelled_reg  <= '0;
            total_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_row_reg  <= '0;
            lvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            region_reg    <= region_next;
            labelled_reg  <= labelled_next;
            total_reg     <= total_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            scan_row_reg  <= scan_row_next;
            lvalid_reg    <= lvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clr_reg       <= clr_next;
        seed_row_reg  <= seed_row_next;
        seed_col_reg  <= seed_col_next;
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        thr_sq_reg    <= thr_sq_next;
        scan_col_reg  <= scan_col_next;
        cur_reg       <= cur_next;
        cur_px_reg    <= cur_px_next;
        nb_reg        <= nb_next;
        ni_reg        <= ni_next;
        d0_reg        <= d0_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        sq0_reg       <= sq0_next;
        sq1_reg       <= sq1_next;
        sq2_reg       <= sq2_next;
        free_reg      <= free_next;
        out_label_reg <= out_label_next;
        out_count_reg <= out_count_next;
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_waddr] <= pix_wdata;
        pix_rdata_reg <= pix_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
            lab_mem[lab_waddr] <= lab_wdata;
        lab_rdata_reg <= lab_mem[lab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
        q_rdata_reg <= q_mem[q_raddr];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.label        = out_label_reg;
    assign rsp.region_count = out_count_reg;

    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("pending queue head passed tail");

    a_labelled: assert property (@(posedge clk) disable iff (!rst_n)
        labelled_reg <= total_reg)
        else $error("more pixels labelled than in the image");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE ||
                                  $past(state_reg) == ST_READ_W))
        else $error("result raised outside a result state");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE || state_reg == ST_READ_W) |-> !out_valid_reg)
        else $error("result register busy when a result is produced");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the region growing labeler top level.
`timescale 1ns / 1ps
module testbench;
    import rgl_pkg::*;

    localparam int IDLE_LIMIT = 400000;

    // Command code the labeler does not know
    localparam logic [1:0] CMD_BAD = 2'd3;

    // Request item as driven on the request channel
    typedef struct {
        logic [1:0] command;
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } pix_req_t;

    typedef struct {
        logic [12:0] label;
        logic [12:0] region_count;
    } label_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgl_req_if req_ch ();
    rgl_rsp_if rsp_ch ();

    region_growing_labeler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, period 2 ns
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow state of the labeler
    logic [23:0] pix_mem [STORE_SIZE];
    int unsigned lab_mem [STORE_SIZE];
    int unsigned bfs_q [STORE_SIZE];
    int unsigned regions;
    int unsigned thr_shadow;
    bit          color_shadow;
    int unsigned rows_shadow;
    int unsigned cols_shadow;

    pix_req_t   pending_reqs [$];
    label_rsp_t expected_labels [$];

    int  src_idle_pct;
    int  snk_stall_pct;
    int  errors;
    int  quiet_cycles;
    bit  req_fire;

    function automatic int unsigned clamp_size(int unsigned v);
        if (v == 0)
            return 1;
        return (v > 64) ? 64 : v;
    endfunction

    function automatic bit pixels_join(logic [23:0] a, logic [23:0] b);
        int unsigned s;
        int d;
        s = 0;
        if (!color_shadow)
        begin
            d = int'(a[7:0]) - int'(b[7:0]);
            if (d < 0) d = -d;
            return d < thr_shadow;
        end
        for (int k = 0; k < 3; k++)
        begin
            d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            s += d * d;
        end
        return s < thr_shadow * thr_shadow;
    endfunction

    // Breadth-first labeling of the whole image in use
    task automatic grow_regions(int unsigned sr, int unsigned sc);
        int unsigned rows, cols, total, done_cnt, head, tail, cur, scan, ni;
        int nr, nc;
        bit found;
        int dr [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
        int dc [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
        rows = clamp_size(rows_shadow);
        cols = clamp_size(cols_shadow);
        total = rows * cols;
        foreach (lab_mem[i]) lab_mem[i] = 0;
        regions = 0;
        done_cnt = 0;
        scan = 0;
        if (sr >= rows || sc >= cols)
        begin
            sr = 0;
            sc = 0;
        end
        while (done_cnt < total)
        begin
            head = 0;
            tail = 0;
            regions++;
            lab_mem[sr * 64 + sc] = regions;
            done_cnt++;
            bfs_q[tail++] = sr * 64 + sc;
            while (head < tail)
            begin
                cur = bfs_q[head++];
                for (int i = 0; i < 8; i++)
                begin
                    nr = int'(cur / 64) + dr[i];
                    nc = int'(cur % 64) + dc[i];
                    if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols))
                        continue;
                    ni = nr * 64 + nc;
                    if (lab_mem[ni] == 0 && pixels_join(pix_mem[cur], pix_mem[ni]))
                    begin
                        lab_mem[ni] = regions;
                        done_cnt++;
                        bfs_q[tail++] = ni;
                    end
                end
            end
            found = 0;
            for (int r = scan; r < rows && !found; r++)
                for (int c = 0; c < cols && !found; c++)
                    if (lab_mem[r * 64 + c] == 0)
                    begin
                        sr = r;
                        sc = c;
                        scan = r;
                        found = 1;
                    end
            if (!found)
                break;
        end
    endtask

    // Predict the result of one accepted request
    task automatic predict_request(pix_req_t q);
        label_rsp_t e;
        case (q.command)
            CMD_LOAD:
                pix_mem[q.row * 64 + q.col] = {q.chan2, q.chan1, q.chan0};
            CMD_GROW:
            begin
                grow_regions(q.row, q.col);
                e.label = '0;
                e.region_count = 13'(regions);
                expected_labels.insert(expected_labels.size(), e);
            end
            CMD_READ:
            begin
                e.label = 13'(lab_mem[q.row * 64 + q.col]);
                e.region_count = 13'(regions);
                expected_labels.insert(expected_labels.size(), e);
            end
            default: ;
        endcase
    endtask

    // Request handshake seen at the last rising edge
    always @(posedge clk)
        req_fire <= req_ch.valid && req_ch.ready;

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fire)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                req_ch.valid   <= 1'b1;
                req_ch.command <= pending_reqs[0].command;
                req_ch.row     <= pending_reqs[0].row;
                req_ch.col     <= pending_reqs[0].col;
                req_ch.chan0   <= pending_reqs[0].chan0;
                req_ch.chan1   <= pending_reqs[0].chan1;
                req_ch.chan2   <= pending_reqs[0].chan2;
                void'(pending_reqs.pop_front());
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result sink backpressure
    always @(negedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);

    // Monitor: predict on request, check on result, watchdog
    always @(posedge clk)
    begin
        pix_req_t q;
        label_rsp_t e;
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req_ch.valid && req_ch.ready)
            begin
                q.command = req_ch.command;
                q.row = req_ch.row;
                q.col = req_ch.col;
                q.chan0 = req_ch.chan0;
                q.chan1 = req_ch.chan1;
                q.chan2 = req_ch.chan2;
                predict_request(q);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_labels.size() == 0)
                begin
                    $display("%0t: unexpected result label=%0d count=%0d", $time,
                             rsp_ch.label, rsp_ch.region_count);
                    errors++;
                end
                else
                begin
                    e = expected_labels.pop_front();
                    if (rsp_ch.label !== e.label)
                    begin
                        $display("%0t: label mismatch expected %0d actual %0d", $time,
                                 e.label, rsp_ch.label);
                        errors++;
                    end
                    if (rsp_ch.region_count !== e.region_count)
                    begin
                        $display("%0t: region_count mismatch expected %0d actual %0d",
                                 $time, e.region_count, rsp_ch.region_count);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("** region_growing_labeler_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic queue_req(logic [1:0] cmd, int r, int c, logic [23:0] px);
        pix_req_t q;
        q.command = cmd;
        q.row = 6'(r);
        q.col = 6'(c);
        {q.chan2, q.chan1, q.chan0} = px;
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    // Wait for the channel to drain and the back end to settle
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_labels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_THRESHOLD:  thr_shadow = val & 9'h1FF;
            CFG_COLOR_MODE: color_shadow = val[0];
            CFG_IMAGE_ROWS: rows_shadow = val & 7'h7F;
            default:        cols_shadow = val & 7'h7F;
        endcase
    endtask

    // Fill the image in use, flat or random, optionally with smooth patches
    task automatic load_image(int unsigned rows, int unsigned cols, int kind);
        logic [23:0] base;
        base = 24'($urandom);
        for (int r = 0; r < clamp_size(rows); r++)
            for (int c = 0; c < clamp_size(cols); c++)
                case (kind)
                    0: queue_req(CMD_LOAD, r, c, base);
                    1: queue_req(CMD_LOAD, r, c, 24'($urandom));
                    default: queue_req(CMD_LOAD, r, c,
                                       ((r < 2) ? base : ~base) ^ 24'($urandom_range(7)));
                endcase
    endtask

    task automatic read_some(int unsigned n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(9) == 0)
                queue_req(CMD_READ, $urandom_range(63), $urandom_range(63), 24'($urandom));
            else
                queue_req(CMD_READ, $urandom_range(clamp_size(rows_shadow) - 1),
                          $urandom_range(clamp_size(cols_shadow) - 1), 24'($urandom));
    endtask

    initial
    begin
        int unsigned r, c;
        errors = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_LOAD;
        req_ch.row = '0;
        req_ch.col = '0;
        req_ch.chan0 = '0;
        req_ch.chan1 = '0;
        req_ch.chan2 = '0;
        rsp_ch.ready = 1'b0;
        foreach (lab_mem[i])
        begin
            lab_mem[i] = 0;
            pix_mem[i] = '0;
        end
        regions = 0;
        thr_shadow = 10;
        color_shadow = 0;
        rows_shadow = 64;
        cols_shadow = 64;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reads before any grow, unknown command, then a tiny image
        queue_req(CMD_READ, 0, 0, '0);
        queue_req(CMD_READ, 63, 63, '0);
        queue_req(CMD_BAD, 5, 5, 24'hFFFFFF);
        wait_idle();
        write_reg(CFG_IMAGE_ROWS, 0);
        write_reg(CFG_IMAGE_COLS, 0);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_COLOR_MODE, 0);
        queue_req(CMD_LOAD, 0, 0, 24'h000000);
        queue_req(CMD_LOAD, 63, 63, 24'hFFFFFF);
        queue_req(CMD_GROW, 63, 63, '0);
        queue_req(CMD_READ, 0, 0, '0);
        queue_req(CMD_READ, 63, 63, '0);
        wait_idle();
        write_reg(CFG_IMAGE_ROWS, 3);
        write_reg(CFG_IMAGE_COLS, 4);
        write_reg(CFG_THRESHOLD, 443);
        write_reg(CFG_COLOR_MODE, 1);
        queue_req(CMD_LOAD, 0, 0, 24'h000000);
        queue_req(CMD_LOAD, 0, 1, 24'hFFFFFF);
        queue_req(CMD_LOAD, 0, 2, 24'h00FF00);
        queue_req(CMD_LOAD, 0, 3, 24'hFF00FF);
        queue_req(CMD_LOAD, 1, 0, 24'h0000FF);
        queue_req(CMD_LOAD, 1, 1, 24'hFF0000);
        queue_req(CMD_LOAD, 1, 2, 24'h808080);
        queue_req(CMD_LOAD, 1, 3, 24'h7F7F7F);
        queue_req(CMD_LOAD, 2, 0, 24'h010101);
        queue_req(CMD_LOAD, 2, 1, 24'hFEFEFE);
        queue_req(CMD_LOAD, 2, 2, 24'h55AA55);
        queue_req(CMD_LOAD, 2, 3, 24'hAA55AA);
        queue_req(CMD_GROW, 2, 3, '0);
        queue_req(CMD_READ, 1, 2, '0);
        queue_req(CMD_READ, 50, 50, '0);
        wait_idle();

        // Random phases: several settings and idling mixes
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
                default: begin src_idle_pct = 29; snk_stall_pct = 29; end
            endcase
            r = $urandom_range(1, 6);
            c = $urandom_range(1, 6);
            // Oversized settings saturate to the full store size
            if (ph == 5)
                r = 127;
            if (ph == 10)
                c = 127;
            write_reg(CFG_IMAGE_ROWS, r);
            write_reg(CFG_IMAGE_COLS, c);
            write_reg(CFG_COLOR_MODE, $urandom_range(1));
            write_reg(CFG_THRESHOLD, (ph % 3 == 0) ? $urandom_range(511) :
                                     $urandom_range(40));
            load_image(r, c, $urandom_range(2));
            for (int g = 0; g < 3; g++)
            begin
                if (g == 1)
                    queue_req(CMD_LOAD, $urandom_range(clamp_size(r) - 1),
                              $urandom_range(clamp_size(c) - 1), 24'($urandom));
                queue_req(CMD_GROW, $urandom_range(7), $urandom_range(7), '0);
                read_some(4);
                queue_req(CMD_BAD, $urandom_range(63), $urandom_range(63), 24'($urandom));
            end
            // Hold off until everything queued so far has come back
            if (ph == 7)
                wait_idle();
            wait_idle();
        end

        wait_idle();
        if (errors == 0)
            $display("** region_growing_labeler_top: PASSED **");
        else
            $display("** region_growing_labeler_top: FAILED **");
        $finish;
    end

endmodule
